// ----- sv/blsbd_pkg.sv -----
package blsbd_pkg;

	localparam int unsigned LEVEL_W      = 8;
	localparam int unsigned BAND_INDEX_W = 3;

	typedef logic [LEVEL_W-1:0]      level_t;
	typedef logic [BAND_INDEX_W-1:0] band_index_t;

	localparam level_t MARGIN_RESET = 8'd40;

	// floor(x / 5) for x below 2**11 as (x * 13108) >> 16.
	localparam int unsigned SMOOTH_NUM_W = 11;
	localparam int unsigned DIV5_SHIFT   = 16;
	localparam logic [13:0] DIV5_RECIP   = 14'd13108;

	// Shift used for the reciprocal division of the band group sums.
	localparam int unsigned RECIP_SHIFT = 20;

	localparam int unsigned HIST_DEPTH  = 8;
	localparam int unsigned HIST_PTR_W  = 3;
	localparam int unsigned RING_SUM_W  = 11;

	typedef logic [HIST_PTR_W-1:0] hist_ptr_t;
	typedef logic [RING_SUM_W-1:0] ring_sum_t;

endpackage

// ----- sv/blsbd_level_if.sv -----
interface blsbd_level_if;
	logic                 valid;
	logic                 ready;
	blsbd_pkg::level_t    band_level;

	modport source (output valid, output band_level, input ready);
	modport sink (input valid, input band_level, output ready);
endinterface

// ----- sv/blsbd_result_if.sv -----
interface blsbd_result_if;
	logic                   valid;
	logic                   ready;
	blsbd_pkg::band_index_t band_index;
	blsbd_pkg::level_t      smoothed_level;
	logic                   frame_done;
	blsbd_pkg::level_t      bass_level;
	blsbd_pkg::level_t      mid_level;
	blsbd_pkg::level_t      high_level;
	blsbd_pkg::level_t      volume_level;
	logic                   beat_flag;

	modport source (
		output valid, output band_index, output smoothed_level, output frame_done,
		output bass_level, output mid_level, output high_level, output volume_level,
		output beat_flag, input ready
	);
	modport sink (
		input valid, input band_index, input smoothed_level, input frame_done,
		input bass_level, input mid_level, input high_level, input volume_level,
		input beat_flag, output ready
	);
endinterface

// ----- sv/band_level_smoother_beat_detector.sv -----
// Band level smoother and beat detector.
// The levels channel takes one 8-bit band level per beat, in band order; an
// internal counter names the band and wraps after the last one. Each level
// updates that band's smoothed value to floor((old + 4 * new) / 5).
// The results channel gives one beat per input beat: the band index and its
// new smoothed level. On the last band of a frame it also carries the bass,
// mid, high and overall means and the beat flag; otherwise those are zero.
// Running group sums are kept up to date, so no band is summed at frame end.
// beat_margin is written whenever beat_margin_we is high.
// Each result beat passes through the s1, s2 and output registers after its
// input beat is accepted. It takes one beat per cycle unless the receiver stalls,
// with the smoothing multiply in the first stage and the group divisions in
// the second. Reset clears the smoothed bands, the bass history, the band
// counter and all valid flags, and sets the margin to 40. When the receiver
// stalls, the whole pipeline holds and levels.ready falls in the same cycle.
module band_level_smoother_beat_detector #(
	parameter int unsigned NUM_BANDS  = 8,
	parameter int unsigned LOW_COUNT  = 2,
	parameter int unsigned MID_COUNT  = 3,
	parameter int unsigned HIGH_COUNT = 3
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  beat_margin_we,
	input  blsbd_pkg::level_t     beat_margin,
	blsbd_level_if.sink           levels,
	blsbd_result_if.source        results
);
	import blsbd_pkg::*;

	localparam int unsigned BAND_W     = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
	localparam int unsigned SUM_W      = $clog2(NUM_BANDS * 255 + 1);
	localparam int unsigned HIGH_FIRST = LOW_COUNT + MID_COUNT;
	localparam int unsigned HIGH_END   = HIGH_FIRST + HIGH_COUNT;
	localparam int unsigned PROD5_W    = SMOOTH_NUM_W + 14;
	localparam logic [BAND_W-1:0] LAST_BAND = BAND_W'(NUM_BANDS - 1);

	logic                    adv;
	logic [BAND_W-1:0]       band_q;
	level_t                  margin_q;

	logic                    valid_s1;
	logic [BAND_W-1:0]       band_s1;
	level_t                  level_s1;

	level_t                  smoothed_q [NUM_BANDS];
	logic [SUM_W-1:0]        low_sum_q;
	logic [SUM_W-1:0]        mid_sum_q;
	logic [SUM_W-1:0]        high_sum_q;
	logic [SUM_W-1:0]        vol_sum_q;

	logic                    valid_s2;
	logic [BAND_W-1:0]       band_s2;
	level_t                  smoothed_s2;

	level_t                  ring_q [HIST_DEPTH];
	hist_ptr_t               ring_ptr_q;
	ring_sum_t               ring_sum_q;

	logic                    out_valid_q;
	band_index_t             out_band_q;
	level_t                  out_smoothed_q;
	logic                    out_done_q;
	level_t                  out_bass_q;
	level_t                  out_mid_q;
	level_t                  out_high_q;
	level_t                  out_vol_q;
	logic                    out_beat_q;

	level_t                  old_level;
	logic [SMOOTH_NUM_W-1:0] smooth_num;
	logic [PROD5_W-1:0]      smooth_prod;
	level_t                  new_level;
	logic [31:0]             band_ext_s1;
	logic                    in_low;
	logic                    in_mid;
	logic                    in_high;

	logic                    frame_end_s2;
	logic [31:0]             band_ext_s2;
	level_t                  bass_mean;
	level_t                  mid_mean;
	level_t                  high_mean;
	level_t                  vol_mean;
	level_t                  hist_mean;
	logic                    beat;

	assign adv          = !out_valid_q || results.ready;
	assign levels.ready = adv;

	// First stage: smoothing of the current band and the running group sums.
	assign old_level   = smoothed_q[band_s1];
	assign smooth_num  = {3'b000, old_level} + {1'b0, level_s1, 2'b00};
	assign smooth_prod = PROD5_W'(smooth_num) * PROD5_W'(DIV5_RECIP);
	assign new_level   = smooth_prod[DIV5_SHIFT +: LEVEL_W];
	assign band_ext_s1 = 32'(band_s1);
	assign in_low      = band_ext_s1 < LOW_COUNT;
	assign in_mid      = !in_low && (band_ext_s1 < HIGH_FIRST);
	assign in_high     = !in_low && !in_mid && (band_ext_s1 < HIGH_END);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_q     <= '0;
			margin_q   <= MARGIN_RESET;
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			low_sum_q  <= '0;
			mid_sum_q  <= '0;
			high_sum_q <= '0;
			vol_sum_q  <= '0;
			ring_ptr_q <= '0;
			ring_sum_q <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_BANDS; i++) begin
				smoothed_q[i] <= '0;
			end
			for (int i = 0; i < HIST_DEPTH; i++) begin
				ring_q[i] <= '0;
			end
		end else begin
			if (beat_margin_we) begin
				margin_q <= beat_margin;
			end
			if (adv) begin
				valid_s1    <= levels.valid;
				valid_s2    <= valid_s1;
				out_valid_q <= valid_s2;
				if (levels.valid) begin
					band_q <= (band_q == LAST_BAND) ? '0 : band_q + 1'b1;
				end
				if (valid_s1) begin
					smoothed_q[band_s1] <= new_level;
					vol_sum_q <= vol_sum_q - SUM_W'(old_level) + SUM_W'(new_level);
					if (in_low) begin
						low_sum_q <= low_sum_q - SUM_W'(old_level) + SUM_W'(new_level);
					end
					if (in_mid) begin
						mid_sum_q <= mid_sum_q - SUM_W'(old_level) + SUM_W'(new_level);
					end
					if (in_high) begin
						high_sum_q <= high_sum_q - SUM_W'(old_level) + SUM_W'(new_level);
					end
				end
				if (valid_s2 && frame_end_s2) begin
					ring_q[ring_ptr_q] <= bass_mean;
					ring_sum_q <= ring_sum_q - RING_SUM_W'(ring_q[ring_ptr_q])
						+ RING_SUM_W'(bass_mean);
					ring_ptr_q <= ring_ptr_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			band_s1     <= band_q;
			level_s1    <= levels.band_level;
			band_s2     <= band_s1;
			smoothed_s2 <= new_level;
			out_band_q     <= band_ext_s2[BAND_INDEX_W-1:0];
			out_smoothed_q <= smoothed_s2;
			out_done_q     <= frame_end_s2;
			out_bass_q     <= frame_end_s2 ? bass_mean : '0;
			out_mid_q      <= frame_end_s2 ? mid_mean : '0;
			out_high_q     <= frame_end_s2 ? high_mean : '0;
			out_vol_q      <= frame_end_s2 ? vol_mean : '0;
			out_beat_q     <= frame_end_s2 && beat;
		end
	end

	// Second stage: the sums already hold the last band of the frame here.
	assign frame_end_s2 = (band_s2 == LAST_BAND);
	assign band_ext_s2  = 32'(band_s2);

	blsbd_group_mean #(.COUNT(LOW_COUNT), .SUM_W(SUM_W)) u_bass_mean (
		.sum  (low_sum_q),
		.mean (bass_mean)
	);

	blsbd_group_mean #(.COUNT(MID_COUNT), .SUM_W(SUM_W)) u_mid_mean (
		.sum  (mid_sum_q),
		.mean (mid_mean)
	);

	blsbd_group_mean #(.COUNT(HIGH_COUNT), .SUM_W(SUM_W)) u_high_mean (
		.sum  (high_sum_q),
		.mean (high_mean)
	);

	blsbd_group_mean #(.COUNT(NUM_BANDS), .SUM_W(SUM_W)) u_vol_mean (
		.sum  (vol_sum_q),
		.mean (vol_mean)
	);

	assign hist_mean = ring_sum_q[RING_SUM_W-1:HIST_PTR_W];
	assign beat      = {1'b0, bass_mean} > ({1'b0, hist_mean} + {1'b0, margin_q});

	assign results.valid          = out_valid_q;
	assign results.band_index     = out_band_q;
	assign results.smoothed_level = out_smoothed_q;
	assign results.frame_done     = out_done_q;
	assign results.bass_level     = out_bass_q;
	assign results.mid_level      = out_mid_q;
	assign results.high_level     = out_high_q;
	assign results.volume_level   = out_vol_q;
	assign results.beat_flag      = out_beat_q;
endmodule

// ----- sv/blsbd_group_mean.sv -----
module blsbd_group_mean #(
	parameter int unsigned COUNT = 2,
	parameter int unsigned SUM_W = 11
) (
	input  logic [SUM_W-1:0]  sum,
	output blsbd_pkg::level_t mean
);
	import blsbd_pkg::*;

	localparam int unsigned PROD_W = SUM_W + RECIP_SHIFT + 1;
	localparam int unsigned RECIP  = ((1 << RECIP_SHIFT) + COUNT - 1) / COUNT;
	localparam logic [RECIP_SHIFT:0] RECIP_V = (RECIP_SHIFT + 1)'(RECIP);

	logic [PROD_W-1:0] prod;
	logic [SUM_W:0]    quot;

	// The rounded-up reciprocal gives the exact floor for every sum that can occur.
	assign prod = PROD_W'(sum) * PROD_W'(RECIP_V);
	assign quot = prod[PROD_W-1:RECIP_SHIFT];
	assign mean = (quot > (SUM_W + 1)'(255)) ? 8'hFF : quot[7:0];
endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps

module tb;
	import blsbd_pkg::*;

	localparam int unsigned BANDS          = 8;
	localparam int unsigned FRAMES_PER_RUN = 75;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned LONG_HOLD      = 150;

	typedef struct packed {
		band_index_t band;
		level_t      smoothed;
		logic        done;
		level_t      bass;
		level_t      mid;
		level_t      high;
		level_t      vol;
		logic        beat;
	} band_result_t;

	typedef enum int {FRAME_NOISE, FRAME_QUIET, FRAME_BASS_HIT, FRAME_FULL, FRAME_SILENT} frame_style_t;

	class band_frame_scoreboard;
		level_t         bands [BANDS];
		level_t         history [HIST_DEPTH];
		hist_ptr_t      hist_ptr;
		band_index_t    band;
		int unsigned    history_sum;
		level_t         margin;
		band_result_t   expected_results [$];
		int unsigned    errors;

		function new();
			foreach (bands[i]) bands[i] = '0;
			foreach (history[i]) history[i] = '0;
			hist_ptr = '0;
			band = '0;
			history_sum = 0;
			margin = MARGIN_RESET;
			errors = 0;
		endfunction

		function void note_level(level_t lvl);
			band_result_t r;
			int unsigned  bass_sum;
			int unsigned  mid_sum;
			int unsigned  high_sum;
			r = '0;
			bands[band] = level_t'((int'(bands[band]) + 4 * int'(lvl)) / 5);
			r.band = band;
			r.smoothed = bands[band];
			if (band == band_index_t'(BANDS - 1)) begin
				bass_sum = int'(bands[0]) + int'(bands[1]);
				mid_sum = int'(bands[2]) + int'(bands[3]) + int'(bands[4]);
				high_sum = int'(bands[5]) + int'(bands[6]) + int'(bands[7]);
				r.done = 1'b1;
				r.bass = level_t'(bass_sum / 2);
				r.mid = level_t'(mid_sum / 3);
				r.high = level_t'(high_sum / 3);
				r.vol = level_t'((bass_sum + mid_sum + high_sum) / 8);
				r.beat = int'(r.bass) > int'(history_sum / 8) + int'(margin);
				history_sum = history_sum - 32'(history[hist_ptr]) + 32'(r.bass);
				history[hist_ptr] = r.bass;
				hist_ptr = hist_ptr + 1'b1;
				band = '0;
			end else begin
				band = band + 1'b1;
			end
			expected_results.push_back(r);
		endfunction

		function void report(string field, int unsigned exp_val, int unsigned act_val);
			if (exp_val != act_val) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_val,
					act_val);
				errors++;
			end
		endfunction

		function void check_result(band_result_t got);
			band_result_t exp_r;
			if (expected_results.size() == 0) begin
				$display("%0t: result beat with nothing expected, actual %p", $time, got);
				errors++;
				return;
			end
			exp_r = expected_results.pop_front();
			report("band_index", 32'(exp_r.band), 32'(got.band));
			report("smoothed_level", 32'(exp_r.smoothed), 32'(got.smoothed));
			report("frame_done", 32'(exp_r.done), 32'(got.done));
			report("bass_level", 32'(exp_r.bass), 32'(got.bass));
			report("mid_level", 32'(exp_r.mid), 32'(got.mid));
			report("high_level", 32'(exp_r.high), 32'(got.high));
			report("volume_level", 32'(exp_r.vol), 32'(got.vol));
			report("beat_flag", 32'(exp_r.beat), 32'(got.beat));
		endfunction

		function int unsigned pending();
			return expected_results.size();
		endfunction
	endclass

	logic   clk = 1'b0;
	logic   arst_n;
	logic   beat_margin_we;
	level_t beat_margin;

	blsbd_level_if  levels_bus ();
	blsbd_result_if results_bus ();

	band_frame_scoreboard frames_sb = new();

	int unsigned src_idle_pct = 0;
	int unsigned sink_idle_pct = 0;
	bit          hold_request = 1'b0;
	int unsigned hold_left = 0;
	int unsigned quiet_cycles = 0;

	band_level_smoother_beat_detector DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.beat_margin_we (beat_margin_we),
		.beat_margin    (beat_margin),
		.levels         (levels_bus),
		.results        (results_bus)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic send_level(level_t lvl);
		while ($urandom_range(99) < src_idle_pct) begin
			levels_bus.valid <= 1'b0;
			@(posedge clk);
		end
		levels_bus.valid <= 1'b1;
		levels_bus.band_level <= lvl;
		do @(posedge clk); while (!levels_bus.ready);
		frames_sb.note_level(lvl);
	endtask

	function automatic level_t level_for(frame_style_t style, int unsigned b);
		case (style)
			FRAME_QUIET: return level_t'($urandom_range(20));
			FRAME_BASS_HIT: return b < 2 ? level_t'($urandom_range(255, 200)) :
				level_t'($urandom_range(60));
			FRAME_FULL: return 8'hFF;
			FRAME_SILENT: return 8'h00;
			default: return level_t'($urandom_range(255));
		endcase
	endfunction

	task automatic run_frames(int unsigned frames);
		frame_style_t style;
		int unsigned  pick;
		for (int unsigned f = 0; f < frames; f++) begin
			pick = $urandom_range(99);
			if (pick < 45) style = FRAME_NOISE;
			else if (pick < 65) style = FRAME_QUIET;
			else if (pick < 85) style = FRAME_BASS_HIT;
			else if (pick < 93) style = FRAME_FULL;
			else style = FRAME_SILENT;
			for (int unsigned b = 0; b < BANDS; b++) send_level(level_for(style, b));
		end
	endtask

	task automatic drain();
		levels_bus.valid <= 1'b0;
		while (frames_sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_margin(level_t value);
		beat_margin_we <= 1'b1;
		beat_margin <= value;
		@(posedge clk);
		frames_sb.margin = value;
		beat_margin_we <= 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		beat_margin_we <= 1'b0;
		beat_margin <= MARGIN_RESET;
		levels_bus.valid <= 1'b0;
		levels_bus.band_level <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int unsigned b = 0; b < BANDS; b++) send_level(8'hFF);
		for (int unsigned b = 0; b < BANDS; b++) send_level(b < 2 ? 8'hFF : 8'h00);
		for (int unsigned b = 0; b < BANDS; b++) send_level(8'h00);
		drain();

		write_margin(8'hFF);
		src_idle_pct = 23;
		sink_idle_pct = 55;
		run_frames(FRAMES_PER_RUN);
		drain();

		write_margin(8'h00);
		src_idle_pct = 55;
		sink_idle_pct = 23;
		run_frames(FRAMES_PER_RUN);
		drain();

		write_margin(level_t'($urandom_range(254, 1)));
		src_idle_pct = 0;
		sink_idle_pct = 0;
		hold_request = 1'b1;
		run_frames(FRAMES_PER_RUN);
		drain();

		repeat (10) @(posedge clk);
		if (frames_sb.errors == 0 && frames_sb.pending() == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

	initial begin
		band_result_t got;
		results_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (results_bus.valid && results_bus.ready) begin
				got.band = results_bus.band_index;
				got.smoothed = results_bus.smoothed_level;
				got.done = results_bus.frame_done;
				got.bass = results_bus.bass_level;
				got.mid = results_bus.mid_level;
				got.high = results_bus.high_level;
				got.vol = results_bus.volume_level;
				got.beat = results_bus.beat_flag;
				frames_sb.check_result(got);
			end
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left != 0) begin
				hold_left--;
				results_bus.ready <= 1'b0;
			end else begin
				results_bus.ready <= $urandom_range(99) >= sink_idle_pct;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((levels_bus.valid && levels_bus.ready) ||
					(results_bus.valid && results_bus.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: done, errors");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

endmodule

// ----- files.f -----
sv/blsbd_pkg.sv
sv/blsbd_level_if.sv
sv/blsbd_result_if.sv
sv/blsbd_group_mean.sv
sv/band_level_smoother_beat_detector.sv
test/tb.sv
